// ===== design/tgc_pkg.sv =====
`default_nettype none

package tgc_pkg;

    // Event kinds
    localparam logic [1:0] OP_DOWN   = 2'd0;
    localparam logic [1:0] OP_UP     = 2'd1;
    localparam logic [1:0] OP_MOTION = 2'd2;

    // Gesture codes
    localparam logic [2:0] GEST_NONE        = 3'd0;
    localparam logic [2:0] GEST_TAP_RIGHT   = 3'd1;
    localparam logic [2:0] GEST_TAP_LEFT    = 3'd2;
    localparam logic [2:0] GEST_SWIPE_RIGHT = 3'd3;
    localparam logic [2:0] GEST_SWIPE_LEFT  = 3'd4;
    localparam logic [2:0] GEST_DROP        = 3'd5;
    localparam logic [2:0] GEST_SWIPE_DOWN  = 3'd6;
    localparam logic [2:0] GEST_SWIPE_UP    = 3'd7;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_MATCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_LIMIT_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_TIME_LIMIT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_DEVICE_MATCH    = 16'd0;
    localparam logic [15:0] RST_MOVE_LIMIT_X    = 16'd4551;
    localparam logic [15:0] RST_MOVE_LIMIT_Y    = 16'd24273;
    localparam logic [15:0] RST_TAP_TIME_LIMIT  = 16'd500;
    localparam logic [15:0] RST_DROP_TIME_LIMIT = 16'd200;

    // Screen half boundary, 0.5 in Q0.16
    localparam logic [15:0] HALF_SCREEN = 16'd32768;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted event
        logic lookup;    // search slots, register hit and free indexes
        logic execute;   // update slots, register deltas and duration
        logic finish;    // classify and load the result register
    } tgc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register empty or being taken this cycle
    } tgc_status_t;

endpackage

`default_nettype wire

// ===== design/tgc_event_if.sv =====
`default_nettype none

interface tgc_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] device_id;
    logic [31:0] finger;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] time_ms;

    modport source (output valid, output op, output device_id, output finger,
                    output pos_x, output pos_y, output time_ms, input ready);
    modport sink   (input valid, input op, input device_id, input finger,
                    input pos_x, input pos_y, input time_ms, output ready);
endinterface

`default_nettype wire

// ===== design/tgc_result_if.sv =====
`default_nettype none

interface tgc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] gesture;
    logic       slots_full;

    modport source (output valid, output gesture, output slots_full, input ready);
    modport sink   (input valid, input gesture, input slots_full, output ready);
endinterface

`default_nettype wire

// ===== design/tgc_ctrl.sv =====
`default_nettype none

module tgc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  evt_valid,
    output logic                 evt_ready,
    input  tgc_pkg::tgc_status_t status,
    output tgc_pkg::tgc_cmd_t    cmd
);
    import tgc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_CLASS
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign evt_ready    = (state_reg == ST_IDLE);
    assign cmd.capture  = (state_reg == ST_IDLE) && evt_valid;
    assign cmd.lookup   = (state_reg == ST_LOOK);
    assign cmd.execute  = (state_reg == ST_EXEC);
    assign cmd.finish   = (state_reg == ST_CLASS) && status.out_free;

endmodule

`default_nettype wire

// ===== design/tgc_datapath.sv =====
`default_nettype none

module tgc_datapath #(
    parameter int FINGER_SLOTS = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  tgc_pkg::tgc_cmd_t                cmd,
    output tgc_pkg::tgc_status_t             status,
    input  wire                              cfg_write_en,
    input  wire [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tgc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire [1:0]                        in_op,
    input  wire [15:0]                       in_device_id,
    input  wire [31:0]                       in_finger,
    input  wire [15:0]                       in_pos_x,
    input  wire [15:0]                       in_pos_y,
    input  wire [31:0]                       in_time_ms,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [2:0]                       out_gesture,
    output logic                             out_slots_full
);
    import tgc_pkg::*;

    localparam int SLOT_W = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

    // Configuration
    logic [15:0] device_match_reg;
    logic [15:0] move_limit_x_reg;
    logic [15:0] move_limit_y_reg;
    logic [15:0] tap_time_limit_reg;
    logic [15:0] drop_time_limit_reg;

    // Latched event
    logic [1:0]  ev_op_reg;
    logic [15:0] ev_device_reg;
    logic [31:0] ev_finger_reg;
    logic [15:0] ev_x_reg;
    logic [15:0] ev_y_reg;
    logic [31:0] ev_time_reg;

    // Slot store
    logic [FINGER_SLOTS-1:0] slot_busy_reg;
    logic [31:0]             slot_finger_reg     [FINGER_SLOTS];
    logic [31:0]             slot_start_time_reg [FINGER_SLOTS];
    logic [15:0]             slot_start_x_reg    [FINGER_SLOTS];
    logic [15:0]             slot_start_y_reg    [FINGER_SLOTS];

    // Lookup results
    logic              dev_ok_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              hit_next;
    logic [SLOT_W-1:0] hit_idx_next;
    logic              free_next;
    logic [SLOT_W-1:0] free_idx_next;

    // Movement measures
    logic               up_hit_reg;
    logic               full_reg;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic [15:0]        adx_reg;
    logic [15:0]        ady_reg;
    logic [31:0]        dur_reg;
    logic signed [16:0] dx_next;
    logic signed [16:0] dy_next;

    // Result register
    logic       res_valid_reg;
    logic [2:0] res_gesture_reg;
    logic       res_full_reg;
    logic [2:0] gesture_next;

    logic               do_down;
    logic               do_up;
    logic signed [16:0] lx_s;
    logic signed [16:0] ly_s;
    logic               small_x;
    logic               small_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_match_reg    <= RST_DEVICE_MATCH;
            move_limit_x_reg    <= RST_MOVE_LIMIT_X;
            move_limit_y_reg    <= RST_MOVE_LIMIT_Y;
            tap_time_limit_reg  <= RST_TAP_TIME_LIMIT;
            drop_time_limit_reg <= RST_DROP_TIME_LIMIT;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DEVICE_MATCH:    device_match_reg    <= cfg_data;
                CFG_MOVE_LIMIT_X:    move_limit_x_reg    <= cfg_data;
                CFG_MOVE_LIMIT_Y:    move_limit_y_reg    <= cfg_data;
                CFG_TAP_TIME_LIMIT:  tap_time_limit_reg  <= cfg_data;
                CFG_DROP_TIME_LIMIT: drop_time_limit_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_op_reg     <= in_op;
            ev_device_reg <= in_device_id;
            ev_finger_reg <= in_finger;
            ev_x_reg      <= in_pos_x;
            ev_y_reg      <= in_pos_y;
            ev_time_reg   <= in_time_ms;
        end
    end

    // Lowest busy slot holding the finger, and lowest free slot
    always_comb
    begin
        hit_next      = 1'b0;
        hit_idx_next  = '0;
        free_next     = 1'b0;
        free_idx_next = '0;
        for (int i = FINGER_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_busy_reg[i] && (slot_finger_reg[i] == ev_finger_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = SLOT_W'(i);
            end
            if (!slot_busy_reg[i])
            begin
                free_next     = 1'b1;
                free_idx_next = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            dev_ok_reg   <= (ev_device_reg == device_match_reg);
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
        end
    end

    assign do_down = dev_ok_reg && (ev_op_reg == OP_DOWN) && !hit_reg;
    assign do_up   = dev_ok_reg && (ev_op_reg == OP_UP) && hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg <= '0;
        end
        else if (cmd.execute)
        begin
            if (do_down && free_reg)
            begin
                slot_busy_reg[free_idx_reg] <= 1'b1;
            end
            else if (do_up)
            begin
                slot_busy_reg[hit_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && do_down && free_reg)
        begin
            slot_finger_reg[free_idx_reg]     <= ev_finger_reg;
            slot_start_time_reg[free_idx_reg] <= ev_time_reg;
            slot_start_x_reg[free_idx_reg]    <= ev_x_reg;
            slot_start_y_reg[free_idx_reg]    <= ev_y_reg;
        end
    end

    assign dx_next = $signed({1'b0, ev_x_reg}) - $signed({1'b0, slot_start_x_reg[hit_idx_reg]});
    assign dy_next = $signed({1'b0, ev_y_reg}) - $signed({1'b0, slot_start_y_reg[hit_idx_reg]});

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            up_hit_reg <= do_up;
            full_reg   <= do_down && !free_reg;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            adx_reg    <= dx_next[16] ? 16'(-dx_next) : dx_next[15:0];
            ady_reg    <= dy_next[16] ? 16'(-dy_next) : dy_next[15:0];
            dur_reg    <= ev_time_reg - slot_start_time_reg[hit_idx_reg];
        end
    end

    assign lx_s    = $signed({1'b0, move_limit_x_reg});
    assign ly_s    = $signed({1'b0, move_limit_y_reg});
    assign small_x = (adx_reg < move_limit_x_reg);
    assign small_y = (ady_reg < move_limit_y_reg);

    always_comb
    begin
        gesture_next = GEST_NONE;
        if (up_hit_reg)
        begin
            if ((dur_reg < {16'd0, tap_time_limit_reg}) && small_x && small_y)
            begin
                gesture_next = (ev_x_reg > HALF_SCREEN) ? GEST_TAP_RIGHT : GEST_TAP_LEFT;
            end
            else if ((dx_reg > lx_s) && small_y)
            begin
                gesture_next = GEST_SWIPE_RIGHT;
            end
            else if ((dx_reg < -lx_s) && small_y)
            begin
                gesture_next = GEST_SWIPE_LEFT;
            end
            else if ((dy_reg > ly_s) && small_x)
            begin
                gesture_next = (dur_reg < {16'd0, drop_time_limit_reg}) ? GEST_DROP
                                                                         : GEST_SWIPE_DOWN;
            end
            else if ((dy_reg < -ly_s) && small_x)
            begin
                gesture_next = GEST_SWIPE_UP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_gesture_reg <= gesture_next;
            res_full_reg    <= full_reg;
        end
    end

    assign status.out_free = !res_valid_reg || out_ready;
    assign out_valid       = res_valid_reg;
    assign out_gesture     = res_gesture_reg;
    assign out_slots_full  = res_full_reg;

endmodule

`default_nettype wire

// ===== design/touch_gesture_classifier.sv =====
`default_nettype none

// Channel   Modport  Beat contents
// -------   -------  -------------------------------------------------------
// evt       sink     op, device_id, finger, pos_x, pos_y, time_ms
// res       source   gesture, slots_full (one beat for every event beat)
// cfg_*     write    cfg_write_en, cfg_index, cfg_data (no back-pressure)
//
// Each event passes in order through accept, slot search, slot update with delta
// and duration measurement, and classify into the result register; the next
// event may be taken in the cycle after the result is loaded.
// Reset clears all slots to free and loads the default thresholds.
// A stalled result beat holds in the result register; the controller waits
// in the classify step until that register frees.
module touch_gesture_classifier #(
    parameter int FINGER_SLOTS = 8
) (
    input  wire                            clk,
    input  wire                            rst_n,
    tgc_event_if.sink                      evt,
    tgc_result_if.source                   res,
    input  wire                            cfg_write_en,
    input  wire [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgc_pkg::*;

    tgc_cmd_t    cmd;
    tgc_status_t status;
    logic        ctrl_ready;

    // Sequence the event through search, update and classify
    tgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (ctrl_ready),
        .status    (status),
        .cmd       (cmd)
    );

    assign evt.ready = ctrl_ready;

    // Slot store, thresholds, measurement and result register
    tgc_datapath #(
        .FINGER_SLOTS (FINGER_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_op          (evt.op),
        .in_device_id   (evt.device_id),
        .in_finger      (evt.finger),
        .in_pos_x       (evt.pos_x),
        .in_pos_y       (evt.pos_y),
        .in_time_ms     (evt.time_ms),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_gesture    (res.gesture),
        .out_slots_full (res.slots_full)
    );

endmodule

`default_nettype wire
